FILE: design/pf_pkg.sv
package pf_pkg;

   localparam logic [4:0] IDX_I = 5'd8;
   localparam logic [4:0] IDX_J = 5'd9;
   localparam logic [4:0] IDX_Z = 5'd25;
   localparam logic [4:0] CELLS = 5'd25;
   localparam logic [2:0] SIDE_LAST = 3'd4;
   localparam logic [6:0] CHAR_A = 7'd65;
   localparam int LETTERS = 26;

   typedef enum logic [2:0] {
      KIND_START  = 3'd0,
      KIND_KEY    = 3'd1,
      KIND_FINISH = 3'd2,
      KIND_CIPHER = 3'd3,
      KIND_END    = 3'd4
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] idx;
   } letter_type;

   typedef struct packed {
      logic clear;
      logic place_key;
      logic fill_start;
      logic fill_step;
      logic fill_done;
      logic hold;
      logic pair_read;
      logic pick_z;
      logic sq_read;
      logic load_out;
   } ctrl_type;

   typedef struct packed {
      logic ready;
      logic held;
      logic is_letter;
      logic walk_last;
      logic out_empty;
   } stat_type;

   // uppercase, J folds into I
   function automatic letter_type letter_of(input logic [7:0] c);
      logic [7:0] u;
      letter_type r;
      u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
      r.valid = (u >= 8'h41 && u <= 8'h5A);
      r.idx = r.valid ? 5'(u - 8'h41) : 5'd0;
      if (r.idx == IDX_J) begin
         r.idx = IDX_I;
      end
      return r;
   endfunction

   // p / 5 for p < 25
   function automatic logic [2:0] row_of(input logic [4:0] p);
      logic [8:0] m;
      m = 9'(p) * 9'd13;
      return m[8:6];
   endfunction

   function automatic logic [2:0] col_of(input logic [4:0] p);
      logic [2:0] r;
      r = row_of(p);
      return 3'(p - 5'({2'b00, r} << 2) - {2'b00, r});
   endfunction

   function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
      return 5'(({2'b00, r} << 2) + {2'b00, r} + {2'b00, c});
   endfunction

   function automatic logic [2:0] dec_wrap(input logic [2:0] v);
      return (v == 3'd0) ? SIDE_LAST : 3'(v - 3'd1);
   endfunction

endpackage

FILE: design/pf_datapath.sv
module pf_datapath (
   input  logic               clock,
   input  logic               reset,
   input  pf_pkg::ctrl_type   ctrl,
   output pf_pkg::stat_type   stat,
   input  logic [7:0]         req_ch,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [6:0]         rsp_char,
   output logic               rsp_last
);

   pf_pkg::letter_type letter;

   logic [25:0] present_ff, present_in;
   logic [4:0]  fill_ff, fill_in;
   logic        ready_ff, ready_in;
   logic        held_ff, held_in;
   logic [4:0]  held_letter_ff;
   logic [4:0]  walk_ff, walk_in;
   logic [1:0]  out_cnt_ff, out_cnt_in;
   logic [4:0]  out0_ff, out1_ff;

   logic [4:0] pos_mem [pf_pkg::LETTERS];
   logic [4:0] sq_mem [25];
   logic [4:0] pos_a_ff, pos_b_ff;
   logic [4:0] sq_a_ff, sq_b_ff;

   logic [4:0] wr_letter;
   logic       wr_en;
   logic [4:0] pair_b;
   logic [2:0] ra, ca, rb, cb;
   logic [4:0] na, nb;

   assign letter    = pf_pkg::letter_of(req_ch);
   assign wr_letter = ctrl.fill_step ? walk_ff : letter.idx;
   assign wr_en     = ((ctrl.fill_step && walk_ff != pf_pkg::IDX_J)
                       || (ctrl.place_key && letter.valid))
                      && !present_ff[wr_letter] && (fill_ff < pf_pkg::CELLS);
   assign pair_b    = ctrl.pick_z ? pf_pkg::IDX_Z : letter.idx;

   always_comb begin
      present_in = present_ff;
      fill_in    = fill_ff;
      ready_in   = ready_ff;
      held_in    = held_ff;
      walk_in    = walk_ff;
      out_cnt_in = out_cnt_ff;
      if (ctrl.clear) begin
         present_in = '0;
         fill_in    = '0;
         ready_in   = 1'b0;
         held_in    = 1'b0;
      end else if (wr_en) begin
         present_in[wr_letter] = 1'b1;
         fill_in = fill_ff + 5'd1;
      end
      if (ctrl.fill_done) begin
         ready_in = 1'b1;
         held_in  = 1'b0;
      end
      if (ctrl.hold) begin
         held_in = 1'b1;
      end
      if (ctrl.pair_read) begin
         held_in = 1'b0;
      end
      if (ctrl.fill_start) begin
         walk_in = '0;
      end else if (ctrl.fill_step) begin
         walk_in = walk_ff + 5'd1;
      end
      if (ctrl.load_out) begin
         out_cnt_in = 2'd2;
      end else if (rsp_tvalid && rsp_tready) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         fill_ff    <= '0;
         ready_ff   <= 1'b0;
         held_ff    <= 1'b0;
         walk_ff    <= '0;
         out_cnt_ff <= '0;
      end else begin
         present_ff <= present_in;
         fill_ff    <= fill_in;
         ready_ff   <= ready_in;
         held_ff    <= held_in;
         walk_ff    <= walk_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.hold) begin
         held_letter_ff <= letter.idx;
      end
      if (ctrl.load_out) begin
         out0_ff <= sq_a_ff;
         out1_ff <= sq_b_ff;
      end
   end

   // letter -> cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[wr_letter] <= fill_ff;
      end
      if (ctrl.pair_read) begin
         pos_a_ff <= pos_mem[held_letter_ff];
         pos_b_ff <= pos_mem[pair_b];
      end
   end

   always_comb begin
      ra = pf_pkg::row_of(pos_a_ff);
      ca = pf_pkg::col_of(pos_a_ff);
      rb = pf_pkg::row_of(pos_b_ff);
      cb = pf_pkg::col_of(pos_b_ff);
      if (ca == cb) begin
         na = pf_pkg::cell_of(pf_pkg::dec_wrap(ra), ca);
         nb = pf_pkg::cell_of(pf_pkg::dec_wrap(rb), cb);
      end else if (ra == rb) begin
         na = pf_pkg::cell_of(ra, pf_pkg::dec_wrap(ca));
         nb = pf_pkg::cell_of(rb, pf_pkg::dec_wrap(cb));
      end else begin
         na = pf_pkg::cell_of(ra, cb);
         nb = pf_pkg::cell_of(rb, ca);
      end
   end

   // cell -> letter
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sq_mem[fill_ff] <= wr_letter;
      end
      if (ctrl.sq_read) begin
         sq_a_ff <= sq_mem[na];
         sq_b_ff <= sq_mem[nb];
      end
   end

   assign rsp_tvalid = (out_cnt_ff != 2'd0);
   assign rsp_char   = pf_pkg::CHAR_A + {2'b00, (out_cnt_ff == 2'd2) ? out0_ff : out1_ff};
   assign rsp_last   = (out_cnt_ff == 2'd1);

   assign stat.ready     = ready_ff;
   assign stat.held      = held_ff;
   assign stat.is_letter = letter.valid;
   assign stat.walk_last = (walk_ff == pf_pkg::IDX_Z);
   assign stat.out_empty = (out_cnt_ff == 2'd0);

`ifndef SYNTH
   a_fill_matches_present: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == 32'(fill_ff))
      else $error("fill count disagrees with present letters");
   a_square_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.fill_done |=> fill_ff == pf_pkg::CELLS)
      else $error("square not full after key finish");
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |-> out_cnt_ff == 2'd0)
      else $error("output buffer overwritten");
   a_pair_ready: assert property (@(posedge clock) disable iff (reset)
      ctrl.pair_read |-> ready_ff && (held_ff || ctrl.pick_z))
      else $error("pair decrypt without square or held letter");
`endif

endmodule

FILE: design/pf_controller.sv
module pf_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2:0]         req_kind,
   input  pf_pkg::stat_type   stat,
   output pf_pkg::ctrl_type   ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_POS,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  pf_pkg::KIND_START: begin
                     ctrl.clear = 1'b1;
                  end
                  pf_pkg::KIND_KEY: begin
                     ctrl.place_key = !stat.ready;
                  end
                  pf_pkg::KIND_FINISH: begin
                     if (!stat.ready) begin
                        ctrl.fill_start = 1'b1;
                        state_in = ST_FILL;
                     end
                  end
                  pf_pkg::KIND_CIPHER: begin
                     if (stat.ready && stat.is_letter) begin
                        if (stat.held) begin
                           ctrl.pair_read = 1'b1;
                           state_in = ST_POS;
                        end else begin
                           ctrl.hold = 1'b1;
                        end
                     end
                  end
                  pf_pkg::KIND_END: begin
                     if (stat.ready && stat.held) begin
                        ctrl.pair_read = 1'b1;
                        ctrl.pick_z    = 1'b1;
                        state_in = ST_POS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            ctrl.fill_step = 1'b1;
            if (stat.walk_last) begin
               ctrl.fill_done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_POS: begin
            ctrl.sq_read = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_empty) begin
               ctrl.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/playfair_decryptor.sv
// channel | dir | tdata                 | tuser      | tlast
// req     | in  | [7:0] ch              | [2:0] cmd  | -
// rsp     | out | [6:0] plain_char, [7] 0 | -        | last
//
// Start, key byte and first letter of a pair are taken without leaving idle.
// Finish key: a walk over the alphabet.
// Second letter or end of message: letter-to-cell read, cell-to-letter read, then
// buffer load; the load waits while the previous pair is still in the buffer.
// Reset clears the square-ready flag, letter presence, counters and the output buffer.
// A stalled rsp holds its transaction; req is taken again once the controller is idle.
module playfair_decryptor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic [2:0] req_tuser,   // [2:0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] plain_char, [7] zero
   output logic       rsp_tlast
);

   pf_pkg::ctrl_type ctrl;
   pf_pkg::stat_type stat;
   logic [6:0]       rsp_char;

   pf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   pf_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_ch     (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule
